>>> sv/febw_pkg.sv
`timescale 1ns / 1ps

package febw_pkg;

    localparam int ADDR_W         = 32;
    localparam int CAP_W          = 23;
    localparam int GROUP_W        = 48;
    localparam int SIZE_W         = 32;
    localparam int COUNT_W        = 16;
    localparam int KIB_SHIFT      = 10;
    localparam int REGION_SLOTS   = 4;
    localparam int CFG_INDEX_W    = 3;

    localparam int NUM_REGION_GROUPS_DEF = 4;
    localparam int MAX_BLOCKS_DEF        = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REGION_0 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REGION_1 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REGION_2 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_REGION_3 = 3'd4;

    localparam logic [2:0] STATUS_BLOCK     = 3'd0;
    localparam logic [2:0] STATUS_CAPACITY  = 3'd1;
    localparam logic [2:0] STATUS_ALIGN     = 3'd2;
    localparam logic [2:0] STATUS_TOO_LARGE = 3'd3;
    localparam logic [2:0] STATUS_NOTHING   = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] start_address;
        logic [ADDR_W-1:0] request_length;
    } febw_in_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] block_address;
        logic [ADDR_W-1:0] block_length;
        logic [ADDR_W-1:0] lower_aligned;
        logic              last;
    } febw_out_t;

    function automatic febw_out_t single_word(
        input logic [2:0]        status,
        input logic [ADDR_W-1:0] block_address,
        input logic [ADDR_W-1:0] lower_aligned
    );
        febw_out_t w;
        w               = '0;
        w.status        = status;
        w.block_address = block_address;
        w.lower_aligned = lower_aligned;
        w.last          = 1'b1;
        return w;
    endfunction

endpackage

>>> sv/flash_erase_block_walker.sv
`timescale 1ns / 1ps
// Sequence: checks on the request, then a walk over the region groups to locate the start,
// with a 32-step divider and one multiply when the start falls inside a group, then a
// counting walk and an emitting walk, each taking one block or skipped group per step.
// The emitting walk waits while the output slot is full; one request is taken at a time,
// and in_ready stays low until the walker is back in idle.
// Reset clears the configuration registers to zero and returns the sequencer to idle.
module flash_erase_block_walker
    import febw_pkg::*;
#(
    parameter int NUM_REGION_GROUPS = NUM_REGION_GROUPS_DEF,
    parameter int MAX_BLOCKS        = MAX_BLOCKS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [GROUP_W-1:0]     cfg_wdata,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  febw_in_t               in_data,

    output logic                   out_valid,
    input  logic                   out_ready,
    output febw_out_t              out_data
);

    localparam int GCW      = $clog2(NUM_REGION_GROUPS + 1);
    localparam int NW       = $clog2(MAX_BLOCKS + 1);
    localparam int DIV_CW   = $clog2(ADDR_W);
    localparam int WIDE_W   = ADDR_W + 1;
    localparam int SPAN_W   = GROUP_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_LOC,
        S_SPAN,
        S_DIV,
        S_ROUND,
        S_MUL,
        S_ADD,
        S_DECIDE,
        S_COUNT,
        S_EMIT
    } state_t;

    logic [CAP_W-1:0]   cap_reg;
    logic [GROUP_W-1:0] region_reg [REGION_SLOTS];

    state_t              state_reg,     state_next;
    logic [ADDR_W-1:0]   start_reg,     start_next;
    logic [WIDE_W-1:0]   end_reg,       end_next;
    logic [WIDE_W-1:0]   addr_reg,      addr_next;
    logic [SIZE_W-1:0]   lastsz_reg,    lastsz_next;
    logic [COUNT_W-1:0]  used_reg,      used_next;
    logic [GCW-1:0]      g_reg,         g_next;
    logic [NW-1:0]       n_reg,         n_next;
    logic [NW-1:0]       total_reg,     total_next;
    logic [GROUP_W-1:0]  prod_reg,      prod_next;
    logic [SIZE_W-1:0]   rem_reg,       rem_next;
    logic [ADDR_W-1:0]   quo_reg,       quo_next;
    logic [DIV_CW-1:0]   div_cnt_reg,   div_cnt_next;
    logic [GCW-1:0]      save_g_reg,    save_g_next;
    logic [COUNT_W-1:0]  save_used_reg, save_used_next;
    logic [WIDE_W-1:0]   save_addr_reg, save_addr_next;
    febw_out_t           out_reg,       out_next;
    logic                out_valid_reg, out_valid_next;

    logic [1:0]          g_idx;
    logic [SIZE_W-1:0]   grp_size;
    logic [COUNT_W-1:0]  grp_count;
    logic                g_done;
    logic                slot_free;
    logic                cap_fail;
    logic [SPAN_W-1:0]   span_end;
    logic [WIDE_W-1:0]   div_shift;
    logic                div_ge;
    logic [WIDE_W-1:0]   remaining;
    logic [WIDE_W-1:0]   addr_step;
    logic [WIDE_W-1:0]   start_wide;
    logic [COUNT_W-1:0]  mul_a;
    logic [GROUP_W-1:0]  mul_p;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= '0;
            for (int i = 0; i < REGION_SLOTS; i++)
            begin
                region_reg[i] <= '0;
            end
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index) inside
                CFG_CAPACITY:
                begin
                    cap_reg <= cfg_wdata[CAP_W-1:0];
                end
                CFG_REGION_0, CFG_REGION_1, CFG_REGION_2, CFG_REGION_3:
                begin
                    region_reg[2'(cfg_index - CFG_REGION_0)] <= cfg_wdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign g_idx      = 2'(g_reg);
    assign grp_size   = region_reg[g_idx][SIZE_W-1:0];
    assign grp_count  = region_reg[g_idx][GROUP_W-1:SIZE_W];
    assign g_done     = (g_reg == GCW'(NUM_REGION_GROUPS));
    assign slot_free  = !out_valid_reg || out_ready;
    assign start_wide = {1'b0, start_reg};
    assign cap_fail   = (end_reg > {cap_reg, {KIB_SHIFT{1'b0}}})
                     || (end_reg > {1'b1, {ADDR_W{1'b0}}});
    assign span_end   = SPAN_W'(addr_reg) + SPAN_W'(prod_reg);
    assign div_shift  = {rem_reg, quo_reg[ADDR_W-1]};
    assign div_ge     = (div_shift >= {1'b0, grp_size});
    assign remaining  = end_reg - addr_reg;
    assign addr_step  = addr_reg + {1'b0, grp_size};
    assign mul_a      = (state_reg == S_MUL) ? used_reg : grp_count;
    assign mul_p      = mul_a * grp_size;

    always_comb
    begin
        state_next     = state_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        addr_next      = addr_reg;
        lastsz_next    = lastsz_reg;
        used_next      = used_reg;
        g_next         = g_reg;
        n_next         = n_reg;
        total_next     = total_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_cnt_next   = div_cnt_reg;
        save_g_next    = save_g_reg;
        save_used_next = save_used_reg;
        save_addr_next = save_addr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    start_next = in_data.start_address;
                    end_next   = {1'b0, in_data.start_address}
                               + {1'b0, in_data.request_length};
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (cap_fail)
                begin
                    if (slot_free)
                    begin
                        out_next       = single_word(STATUS_CAPACITY, '0, '0);
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    addr_next   = '0;
                    lastsz_next = '0;
                    used_next   = '0;
                    g_next      = '0;
                    state_next  = S_LOC;
                end
            end
            S_LOC:
            begin
                if (g_done || addr_reg >= start_wide)
                begin
                    state_next = S_DECIDE;
                end
                else if (grp_size == '0 || grp_count == '0)
                begin
                    g_next = g_reg + 1'b1;
                end
                else
                begin
                    prod_next  = mul_p;
                    state_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                if (span_end <= SPAN_W'(start_reg))
                begin
                    addr_next   = WIDE_W'(span_end);
                    lastsz_next = grp_size;
                    g_next      = g_reg + 1'b1;
                    state_next  = S_LOC;
                end
                else
                begin
                    rem_next     = '0;
                    quo_next     = start_reg - addr_reg[ADDR_W-1:0];
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next     = div_ge ? SIZE_W'(div_shift - {1'b0, grp_size})
                                      : div_shift[SIZE_W-1:0];
                quo_next     = {quo_reg[ADDR_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CW'(ADDR_W - 1))
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                used_next  = quo_reg[COUNT_W-1:0] + COUNT_W'(rem_reg != '0);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = mul_p;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                addr_next   = addr_reg + prod_reg[WIDE_W-1:0];
                lastsz_next = grp_size;
                state_next  = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (addr_reg < start_wide)
                begin
                    if (slot_free)
                    begin
                        out_next       = single_word(STATUS_CAPACITY, '0, '0);
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (addr_reg > start_wide)
                begin
                    if (slot_free)
                    begin
                        out_next       = single_word(STATUS_ALIGN, addr_reg[ADDR_W-1:0],
                                                     addr_reg[ADDR_W-1:0] - lastsz_reg);
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (end_reg == start_wide)
                begin
                    if (slot_free)
                    begin
                        out_next       = single_word(STATUS_NOTHING, start_reg, '0);
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    save_g_next    = g_reg;
                    save_used_next = used_reg;
                    save_addr_next = addr_reg;
                    n_next         = '0;
                    state_next     = S_COUNT;
                end
            end
            S_COUNT:
            begin
                if (g_done || addr_reg >= end_reg)
                begin
                    if (n_reg == '0)
                    begin
                        if (slot_free)
                        begin
                            out_next       = single_word(STATUS_CAPACITY, '0, '0);
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    else
                    begin
                        total_next = n_reg;
                        n_next     = '0;
                        g_next     = save_g_reg;
                        used_next  = save_used_reg;
                        addr_next  = save_addr_reg;
                        state_next = S_EMIT;
                    end
                end
                else if (grp_size == '0 || used_reg >= grp_count)
                begin
                    g_next    = g_reg + 1'b1;
                    used_next = '0;
                end
                else if (n_reg == NW'(MAX_BLOCKS))
                begin
                    if (slot_free)
                    begin
                        out_next       = single_word(STATUS_TOO_LARGE, '0, '0);
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    addr_next = addr_step;
                    used_next = used_reg + 1'b1;
                    n_next    = n_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (g_done || addr_reg >= end_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (grp_size == '0 || used_reg >= grp_count)
                begin
                    g_next    = g_reg + 1'b1;
                    used_next = '0;
                end
                else if (slot_free)
                begin
                    out_next.status        = STATUS_BLOCK;
                    out_next.block_address = addr_reg[ADDR_W-1:0];
                    out_next.block_length  = (remaining < {1'b0, grp_size})
                                           ? remaining[ADDR_W-1:0] : grp_size;
                    out_next.lower_aligned = '0;
                    out_next.last          = (n_reg + 1'b1 == total_reg);
                    out_valid_next         = 1'b1;
                    addr_next              = addr_step;
                    used_next              = used_reg + 1'b1;
                    n_next                 = n_reg + 1'b1;
                    if (n_reg + 1'b1 == total_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            g_reg         <= '0;
            n_reg         <= '0;
            total_reg     <= '0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            g_reg         <= g_next;
            n_reg         <= n_next;
            total_reg     <= total_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg     <= start_next;
        end_reg       <= end_next;
        addr_reg      <= addr_next;
        lastsz_reg    <= lastsz_next;
        used_reg      <= used_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        save_g_reg    <= save_g_next;
        save_used_reg <= save_used_next;
        save_addr_reg <= save_addr_next;
        out_reg       <= out_next;
    end

    ast_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STATUS_BLOCK |-> out_data.last)
        else $error("error word without last");

    ast_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while walker still busy");

    ast_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> n_reg < total_reg && total_reg != '0)
        else $error("emit index ran past block total");

    ast_align_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == STATUS_ALIGN
            |-> out_data.block_address != out_data.lower_aligned)
        else $error("alignment bounds coincide");

endmodule

>>> tb/flash_erase_block_walker_test.sv
`timescale 1ns / 1ps

import febw_pkg::*;

class erase_scoreboard;
    localparam int REPORT_LIMIT = 100;

    logic [CAP_W-1:0]   capacity_kib;
    logic [GROUP_W-1:0] region_group [REGION_SLOTS];
    febw_out_t          expected_words [$];
    int                 errors;

    function new();
        capacity_kib = '0;
        foreach (region_group[i])
        begin
            region_group[i] = '0;
        end
        errors = 0;
    endfunction

    function void apply_register(input logic [CFG_INDEX_W-1:0] index,
                                 input logic [GROUP_W-1:0] data);
        if (index == CFG_CAPACITY)
        begin
            capacity_kib = data[CAP_W-1:0];
        end
        else if (index <= CFG_REGION_3)
        begin
            region_group[index - CFG_REGION_0] = data;
        end
    endfunction

    function void push_single(input logic [2:0] status, input logic [63:0] addr,
                              input logic [63:0] lower);
        febw_out_t w;
        w               = '0;
        w.status        = status;
        w.block_address = addr[ADDR_W-1:0];
        w.lower_aligned = lower[ADDR_W-1:0];
        w.last          = 1'b1;
        expected_words.push_back(w);
    endfunction

    function void note_request(input febw_in_t req);
        logic [63:0] start;
        logic [63:0] len;
        logic [63:0] stop;
        logic [63:0] addr;
        logic [63:0] last_size;
        logic [63:0] used;
        logic [63:0] cnt;
        logic [63:0] sz;
        logic [63:0] rem;
        febw_out_t   w;
        febw_out_t   walk [$];
        int          g;
        start = 64'(req.start_address);
        len   = 64'(req.request_length);
        stop  = start + len;
        if (stop > (64'(capacity_kib) << KIB_SHIFT) || stop > 64'h1_0000_0000)
        begin
            push_single(STATUS_CAPACITY, 64'd0, 64'd0);
            return;
        end
        addr      = '0;
        last_size = '0;
        used      = '0;
        g         = 0;
        while (g < NUM_REGION_GROUPS_DEF && addr < start)
        begin
            cnt = 64'(region_group[g][47:32]);
            sz  = 64'(region_group[g][31:0]);
            if (sz == 0 || cnt == 0)
            begin
                g++;
            end
            else if (addr + cnt * sz <= start)
            begin
                addr      = addr + cnt * sz;
                last_size = sz;
                g++;
            end
            else
            begin
                used      = (start - addr + sz - 1) / sz;
                addr      = addr + used * sz;
                last_size = sz;
                break;
            end
        end
        if (addr < start)
        begin
            push_single(STATUS_CAPACITY, 64'd0, 64'd0);
            return;
        end
        if (addr > start)
        begin
            push_single(STATUS_ALIGN, addr, addr - last_size);
            return;
        end
        if (len == 0)
        begin
            push_single(STATUS_NOTHING, start, 64'd0);
            return;
        end
        while (g < NUM_REGION_GROUPS_DEF && addr < stop)
        begin
            cnt = 64'(region_group[g][47:32]);
            sz  = 64'(region_group[g][31:0]);
            if (sz == 0 || used >= cnt)
            begin
                g++;
                used = '0;
            end
            else if (walk.size() >= MAX_BLOCKS_DEF)
            begin
                push_single(STATUS_TOO_LARGE, 64'd0, 64'd0);
                return;
            end
            else
            begin
                rem             = stop - addr;
                w               = '0;
                w.status        = STATUS_BLOCK;
                w.block_address = addr[ADDR_W-1:0];
                w.block_length  = (rem < sz) ? rem[ADDR_W-1:0] : sz[ADDR_W-1:0];
                walk.push_back(w);
                addr = addr + sz;
                used = used + 1;
            end
        end
        if (walk.size() == 0)
        begin
            push_single(STATUS_CAPACITY, 64'd0, 64'd0);
            return;
        end
        walk[walk.size() - 1].last = 1'b1;
        foreach (walk[i])
        begin
            expected_words.push_back(walk[i]);
        end
    endfunction

    function void check_word(input febw_out_t got);
        febw_out_t want;
        if (expected_words.size() == 0)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
            begin
                $display("%0t: unexpected word, expected none, got %0d %h %h %h %0d",
                         $time, got.status, got.block_address, got.block_length,
                         got.lower_aligned, got.last);
            end
            return;
        end
        want = expected_words.pop_front();
        if (want.status !== got.status || want.block_address !== got.block_address ||
            want.block_length !== got.block_length ||
            want.lower_aligned !== got.lower_aligned || want.last !== got.last)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
            begin
                $display("%0t: expected %0d %h %h %h %0d, got %0d %h %h %h %0d",
                         $time, want.status, want.block_address, want.block_length,
                         want.lower_aligned, want.last, got.status, got.block_address,
                         got.block_length, got.lower_aligned, got.last);
            end
        end
    endfunction
endclass

module flash_erase_block_walker_test;
    import febw_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_wen   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [GROUP_W-1:0]     cfg_wdata = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    febw_in_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    febw_out_t              out_data;

    erase_scoreboard board;
    int              send_idle   = 0;
    int              recv_stall  = 0;
    int              hold_cycles = 0;
    int              cycle_count = 0;

    flash_erase_block_walker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                board.check_word(out_data);
            end
            // hold off the receiver while a pressure stretch is pending
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [GROUP_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge clk);
        board.apply_register(index, data);
    endtask

    task automatic load_configuration(input logic [CAP_W-1:0] cap,
                                      input logic [GROUP_W-1:0] g0,
                                      input logic [GROUP_W-1:0] g1,
                                      input logic [GROUP_W-1:0] g2,
                                      input logic [GROUP_W-1:0] g3);
        logic [GROUP_W-1:0] grp [REGION_SLOTS];
        int                 i;
        grp[0] = g0;
        grp[1] = g1;
        grp[2] = g2;
        grp[3] = g3;
        write_register(CFG_CAPACITY, {25'($urandom), cap});
        for (i = 0; i < REGION_SLOTS; i++)
        begin
            write_register(CFG_REGION_0 + CFG_INDEX_W'(i), grp[i]);
        end
        write_register(CFG_REGION_3 + CFG_INDEX_W'($urandom_range(3, 1)),
                       {$urandom, 16'($urandom)});
        cfg_wen <= 1'b0;
    endtask

    task automatic send_request(input febw_in_t req);
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        board.note_request(req);
        if (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
            begin
                @(posedge clk);
            end
        end
    endtask

    task automatic drain(input int settle);
        in_valid <= 1'b0;
        while (board.expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    function automatic logic [63:0] block_start(input logic [63:0] k, output logic [63:0] sz);
        logic [63:0] base;
        logic [63:0] cnt;
        logic [63:0] s;
        int          g;
        base = '0;
        sz   = '0;
        for (g = 0; g < REGION_SLOTS; g++)
        begin
            cnt = 64'(board.region_group[g][47:32]);
            s   = 64'(board.region_group[g][31:0]);
            if (s != 0 && cnt != 0)
            begin
                if (k < cnt)
                begin
                    sz = s;
                    return base + k * s;
                end
                k    = k - cnt;
                base = base + cnt * s;
            end
        end
        return base;
    endfunction

    function automatic febw_in_t make_request();
        febw_in_t    req;
        logic [63:0] total;
        logic [63:0] k;
        logic [63:0] base;
        logic [63:0] sz;
        logic [63:0] room;
        int          g;
        total = '0;
        for (g = 0; g < REGION_SLOTS; g++)
        begin
            if (board.region_group[g][31:0] != 0)
            begin
                total = total + 64'(board.region_group[g][47:32]);
            end
        end
        req.start_address  = $urandom;
        req.request_length = $urandom_range(65536, 0);
        if (total != 0 && $urandom_range(99) < 85)
        begin
            k    = ($urandom_range(1) ? 64'($urandom) : 64'($urandom_range(15, 0))) % total;
            base = block_start(k, sz);
            req.start_address = base[31:0];
            case ($urandom_range(9, 0))
                0: req.request_length = '0;
                1, 2, 3: req.request_length = $urandom_range(sz[31:0], 1);
                4, 5: req.request_length = $urandom_range(200000, 1);
                6: req.request_length = sz[31:0] * $urandom_range(4, 1);
                7:
                begin
                    room = (64'(board.capacity_kib) << KIB_SHIFT) - base;
                    req.request_length = room[31:0] + $urandom_range(2, 0) - 1;
                end
                8: req.request_length = $urandom;
                default:
                begin
                    if (sz > 1)
                    begin
                        req.start_address = base[31:0] + $urandom_range(sz[31:0] - 1, 1);
                    end
                end
            endcase
        end
        return req;
    endfunction

    task automatic random_configuration();
        logic [GROUP_W-1:0] grp [REGION_SLOTS];
        logic [63:0]        total;
        logic [31:0]        size;
        logic [CAP_W-1:0]   cap;
        bit                 wide;
        int                 g;
        total = '0;
        wide  = ($urandom_range(3, 0) == 0);
        for (g = 0; g < REGION_SLOTS; g++)
        begin
            case ($urandom_range(4, 0))
                0: size = 32'd512;
                1: size = 32'd1024;
                2: size = 32'd4096;
                3: size = 32'd65536;
                default: size = $urandom_range(20000, 1);
            endcase
            case ($urandom_range(9, 0))
                0: grp[g] = {16'($urandom_range(8, 1)), 32'd0};
                1: grp[g] = {16'd0, size};
                2: grp[g] = {16'($urandom_range(150, 65)), 32'd512};
                default: grp[g] = {16'($urandom_range(10, 1)), size};
            endcase
            if (wide && g == 2)
            begin
                grp[g] = {16'($urandom_range(3, 1)), 32'h1000_0000 << $urandom_range(3, 0)};
            end
            if (grp[g][31:0] != 0)
            begin
                total = total + 64'(grp[g][47:32]) * 64'(grp[g][31:0]);
            end
        end
        if (wide)
        begin
            cap = 23'd4194304;
        end
        else if ($urandom_range(3, 0) == 0)
        begin
            cap = CAP_W'(total >> 11);
        end
        else
        begin
            cap = CAP_W'((total >> KIB_SHIFT) + 64'($urandom_range(4, 0)));
        end
        load_configuration(cap, grp[0], grp[1], grp[2], grp[3]);
    endtask

    task automatic run_phase(input int items, input int s_idle, input int r_stall,
                             input int hold);
        int i;
        send_idle   = s_idle;
        recv_stall  = r_stall;
        hold_cycles = hold;
        random_configuration();
        for (i = 0; i < items; i++)
        begin
            send_request(make_request());
        end
        drain(8);
    endtask

    initial
    begin
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at their reset values
        send_request({32'd0, 32'd0});
        send_request({32'd0, 32'd1});
        drain(8);

        load_configuration(23'd64, {16'd4, 32'd1024}, {16'd5, 32'd0},
                           {16'd3, 32'd4096}, {16'd2, 32'd16384});
        send_request({32'd0, 32'd0});
        send_request({32'd0, 32'd1});
        send_request({32'd0, 32'd1024});
        send_request({32'd0, 32'd1025});
        send_request({32'd1024, 32'd5000});
        send_request({32'd512, 32'd10});
        send_request({32'd5000, 32'd1});
        send_request({32'd0, 32'd49152});
        send_request({32'd32768, 32'd30000});
        send_request({32'd49152, 32'd1});
        send_request({32'd60000, 32'd1});
        send_request({32'd0, 32'd65537});
        send_request({32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_request({32'hFFFF_FFFF, 32'd1});
        drain(8);

        load_configuration(23'd200, {16'd0, 32'd4096}, {16'd100, 32'd1024}, 48'd0, 48'd0);
        send_request({32'd0, 32'd65536});
        send_request({32'd0, 32'd65537});
        send_request({32'd1024, 32'd66560});
        drain(8);

        load_configuration(23'd4194304, {16'd1, 32'hFFFF_FFFE}, {16'hFFFF, 32'h8000_0000},
                           48'd0, 48'hFFFF_FFFF_FFFF);
        send_request({32'd0, 32'hFFFF_FFFF});
        send_request({32'hFFFF_FFFE, 32'd1});
        send_request({32'hFFFF_FFFF, 32'd0});
        send_request({32'hFFFF_FFFF, 32'd1});
        send_request({32'd1, 32'd0});
        drain(8);

        run_phase(41, 0, 0, 0);
        run_phase(41, 72, 0, 0);
        run_phase(41, 0, 72, 0);
        run_phase(41, 26, 26, 0);
        run_phase(41, 0, 0, 2000);
        run_phase(41, 26, 26, 0);

        repeat (40) @(posedge clk);
        if (board.errors == 0 && board.expected_words.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
